// ===== hdl/tow_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tow_pkg: shared types and constants of the transient onset window detector
// Holds the word formats of both channels, the register map, the register
// reset values and the event word that passes from front end to back end.
// ============================================================================
package tow_pkg;

   // Field widths of the channel words.
   localparam int INDEX_BITS = 20;
   localparam int LEVEL_BITS = 16;
   localparam int CONF_BITS  = 16;

   // Register port geometry.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_SEL_BITS  = 3;

   // Register indexes.
   localparam logic [REG_SEL_BITS-1:0] REG_ONSET_THRESHOLD = 3'd0;
   localparam logic [REG_SEL_BITS-1:0] REG_FLOOR_LEVEL     = 3'd1;
   localparam logic [REG_SEL_BITS-1:0] REG_MIN_DURATION    = 3'd2;
   localparam logic [REG_SEL_BITS-1:0] REG_MAX_DURATION    = 3'd3;
   localparam logic [REG_SEL_BITS-1:0] REG_MIN_GAP         = 3'd4;

   // Register reset values.
   localparam logic signed [LEVEL_BITS-1:0] RESET_ONSET_THRESHOLD = 16'sd1536;
   localparam logic signed [LEVEL_BITS-1:0] RESET_FLOOR_LEVEL     = -16'sd15360;
   localparam logic [INDEX_BITS-1:0]        RESET_MIN_DURATION    = 20'd2;
   localparam logic [INDEX_BITS-1:0]        RESET_MAX_DURATION    = 20'd100;
   localparam logic [INDEX_BITS-1:0]        RESET_MIN_GAP         = 20'd5;

   // Confidence end points, 0.0 and saturated 1.0.
   localparam logic [CONF_BITS-1:0] CONF_ZERO = '0;
   localparam logic [CONF_BITS-1:0] CONF_ONE  = '1;

   // Input word.
   typedef struct packed {
      logic signed [LEVEL_BITS-1:0] frame_level;
      logic                         final_item;
   } tow_req_type;

   // Result word.
   typedef struct packed {
      logic [INDEX_BITS-1:0] start_index;
      logic [INDEX_BITS-1:0] end_index;
      logic [CONF_BITS-1:0]  confidence;
      logic                  last_of_run;
   } tow_rsp_type;

   // Register file contents.
   typedef struct packed {
      logic signed [LEVEL_BITS-1:0] onset_threshold;
      logic signed [LEVEL_BITS-1:0] floor_level;
      logic [INDEX_BITS-1:0]        min_duration_frames;
      logic [INDEX_BITS-1:0]        max_duration_frames;
      logic [INDEX_BITS-1:0]        min_gap_frames;
   } tow_cfg_type;

   // Event word: a closed window of sufficient length and/or a flush request.
   typedef struct packed {
      logic                         has_window;
      logic                         flush;
      logic [INDEX_BITS-1:0]        start_index;
      logic [INDEX_BITS-1:0]        end_index;
      logic signed [LEVEL_BITS-1:0] peak;
   } tow_event_type;

   // Queue fill status.
   typedef struct packed {
      logic empty;
      logic full;
   } tow_queue_status_type;

endpackage

// ===== hdl/tow_csr.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tow_csr: configuration registers
// APB-style register file with five registers at word addresses, always
// ready, with combinational read data.
// ============================================================================
module tow_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tow_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [tow_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [tow_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output tow_pkg::tow_cfg_type                cfg
);

   tow_pkg::tow_cfg_type                 cfg_ff;
   tow_pkg::tow_cfg_type                 cfg_in;
   logic [tow_pkg::REG_SEL_BITS-1:0]     reg_sel;
   logic                                 write_strobe;

   assign pready       = 1'b1;
   assign reg_sel      = paddr[tow_pkg::CSR_ADDR_BITS-1:2];
   assign write_strobe = psel && penable && pwrite;
   assign cfg          = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         case (reg_sel)
            tow_pkg::REG_ONSET_THRESHOLD: begin
               cfg_in.onset_threshold = pwdata[tow_pkg::LEVEL_BITS-1:0];
            end
            tow_pkg::REG_FLOOR_LEVEL: begin
               cfg_in.floor_level = pwdata[tow_pkg::LEVEL_BITS-1:0];
            end
            tow_pkg::REG_MIN_DURATION: begin
               cfg_in.min_duration_frames = pwdata[tow_pkg::INDEX_BITS-1:0];
            end
            tow_pkg::REG_MAX_DURATION: begin
               cfg_in.max_duration_frames = pwdata[tow_pkg::INDEX_BITS-1:0];
            end
            tow_pkg::REG_MIN_GAP: begin
               cfg_in.min_gap_frames = pwdata[tow_pkg::INDEX_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.onset_threshold     <= tow_pkg::RESET_ONSET_THRESHOLD;
         cfg_ff.floor_level         <= tow_pkg::RESET_FLOOR_LEVEL;
         cfg_ff.min_duration_frames <= tow_pkg::RESET_MIN_DURATION;
         cfg_ff.max_duration_frames <= tow_pkg::RESET_MAX_DURATION;
         cfg_ff.min_gap_frames      <= tow_pkg::RESET_MIN_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux; the level registers read back sign-extended.
   always_comb begin
      case (reg_sel)
         tow_pkg::REG_ONSET_THRESHOLD: begin
            prdata = tow_pkg::CSR_DATA_BITS'(cfg_ff.onset_threshold);
         end
         tow_pkg::REG_FLOOR_LEVEL: begin
            prdata = tow_pkg::CSR_DATA_BITS'(cfg_ff.floor_level);
         end
         tow_pkg::REG_MIN_DURATION: begin
            prdata = tow_pkg::CSR_DATA_BITS'(cfg_ff.min_duration_frames);
         end
         tow_pkg::REG_MAX_DURATION: begin
            prdata = tow_pkg::CSR_DATA_BITS'(cfg_ff.max_duration_frames);
         end
         tow_pkg::REG_MIN_GAP: begin
            prdata = tow_pkg::CSR_DATA_BITS'(cfg_ff.min_gap_frames);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

endmodule

// ===== hdl/tow_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tow_front: frame classifier
// Takes one level word per hop frame, tracks onset and the open window, and
// pushes an event word whenever a window of sufficient length closes or the
// buffer ends.
// ============================================================================
module tow_front (
   input  logic                          clock,
   input  logic                          reset,
   input  tow_pkg::tow_cfg_type          cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tow_pkg::tow_req_type          req_data,
   input  tow_pkg::tow_queue_status_type q_stat,
   output logic                          push,
   output tow_pkg::tow_event_type        push_data
);

   logic [tow_pkg::INDEX_BITS-1:0]        frame_counter_ff, frame_counter_in;
   logic signed [tow_pkg::LEVEL_BITS-1:0] prev_level_ff, prev_level_in;
   logic                                  prev_valid_ff, prev_valid_in;
   logic                                  window_open_ff, window_open_in;
   logic [tow_pkg::INDEX_BITS-1:0]        window_start_ff, window_start_in;
   logic signed [tow_pkg::LEVEL_BITS-1:0] window_peak_ff, window_peak_in;

   logic                                  accept;
   logic                                  final_item;
   logic signed [tow_pkg::LEVEL_BITS-1:0] level;
   logic signed [tow_pkg::LEVEL_BITS-1:0] peak_upd;
   logic signed [tow_pkg::LEVEL_BITS-1:0] close_peak;
   logic signed [tow_pkg::LEVEL_BITS:0]   flux;
   logic signed [tow_pkg::LEVEL_BITS:0]   thr_ext;
   logic [tow_pkg::INDEX_BITS-1:0]        idx;
   logic [tow_pkg::INDEX_BITS-1:0]        idx_back;
   logic [tow_pkg::INDEX_BITS-1:0]        close_start;
   logic [tow_pkg::INDEX_BITS-1:0]        open_span;
   logic [tow_pkg::INDEX_BITS-1:0]        close_span;
   logic                                  open_now;
   logic                                  level_close;
   logic                                  close_any;
   logic                                  kept;

   assign req_ready  = !q_stat.full;
   assign accept     = req_valid && req_ready;
   assign level      = req_data.frame_level;
   assign final_item = req_data.final_item;
   assign idx        = frame_counter_ff;
   assign idx_back   = idx - tow_pkg::INDEX_BITS'(1);

   // Rise detection against the previous frame.
   assign flux    = {level[tow_pkg::LEVEL_BITS-1], level}
                  - {prev_level_ff[tow_pkg::LEVEL_BITS-1], prev_level_ff};
   assign thr_ext = {cfg.onset_threshold[tow_pkg::LEVEL_BITS-1], cfg.onset_threshold};
   assign open_now = prev_valid_ff && !window_open_ff && (flux > thr_ext);

   // Open window: peak tracking and closing by floor or by length.
   assign peak_upd    = (level > window_peak_ff) ? level : window_peak_ff;
   assign open_span   = idx - window_start_ff;
   assign level_close = prev_valid_ff && window_open_ff &&
                        ((level < cfg.floor_level) ||
                         (open_span > cfg.max_duration_frames));

   // A window also closes at the last frame, even one that opened there.
   assign close_any   = level_close ||
                        (final_item && (window_open_ff || open_now));
   assign close_start = open_now ? idx_back : window_start_ff;
   assign close_peak  = open_now ? level : peak_upd;
   assign close_span  = idx - close_start;
   assign kept        = close_any && (close_span >= cfg.min_duration_frames);

   // Event word toward the back end.
   assign push                  = accept && (kept || final_item);
   assign push_data.has_window  = kept;
   assign push_data.flush       = final_item;
   assign push_data.start_index = close_start;
   assign push_data.end_index   = idx;
   assign push_data.peak        = close_peak;

   // Per-buffer state update.
   always_comb begin
      frame_counter_in = frame_counter_ff;
      prev_level_in    = prev_level_ff;
      prev_valid_in    = prev_valid_ff;
      window_open_in   = window_open_ff;
      window_start_in  = window_start_ff;
      window_peak_in   = window_peak_ff;
      if (accept) begin
         if (final_item) begin
            frame_counter_in = '0;
            prev_valid_in    = 1'b0;
            window_open_in   = 1'b0;
         end else begin
            frame_counter_in = idx + tow_pkg::INDEX_BITS'(1);
            prev_level_in    = level;
            prev_valid_in    = 1'b1;
            if (open_now) begin
               window_open_in  = 1'b1;
               window_start_in = idx_back;
               window_peak_in  = level;
            end else if (window_open_ff) begin
               window_peak_in = peak_upd;
               if (level_close) begin
                  window_open_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_counter_ff <= '0;
         prev_valid_ff    <= 1'b0;
         window_open_ff   <= 1'b0;
      end else begin
         frame_counter_ff <= frame_counter_in;
         prev_valid_ff    <= prev_valid_in;
         window_open_ff   <= window_open_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_level_ff   <= prev_level_in;
      window_start_ff <= window_start_in;
      window_peak_ff  <= window_peak_in;
   end

endmodule

// ===== hdl/tow_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tow_queue: event queue
// Small register FIFO that decouples the frame classifier from the
// confidence and merge engine.
// ============================================================================
module tow_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  tow_pkg::tow_event_type        push_data,
   input  logic                          pop,
   output tow_pkg::tow_event_type        pop_data,
   output tow_pkg::tow_queue_status_type stat
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   tow_pkg::tow_event_type  entry_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == COUNT_BITS'(DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0
                   : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0
                   : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/tow_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tow_back: confidence and merge engine
// Pops event words, works out the confidence with a serial restoring divide,
// merges close windows into the held detection and emits result words
// through an output register.
// ============================================================================
module tow_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tow_pkg::tow_cfg_type          cfg,
   input  tow_pkg::tow_queue_status_type q_stat,
   output logic                          pop,
   input  tow_pkg::tow_event_type        pop_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tow_pkg::tow_rsp_type          rsp_data
);

   localparam int LB        = tow_pkg::LEVEL_BITS;
   localparam int STEP_BITS = $clog2(tow_pkg::CONF_BITS);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_DIVIDE  = 4'b0010,
      ST_RESOLVE = 4'b0100,
      ST_FLUSH   = 4'b1000
   } state_type;

   state_type                             state_ff, state_in;
   tow_pkg::tow_event_type                ev_ff, ev_in;
   logic [STEP_BITS-1:0]                  step_ff, step_in;
   logic [LB:0]                           rem_ff, rem_in;
   logic [LB:0]                           den_ff, den_in;
   logic [tow_pkg::CONF_BITS-1:0]         quot_ff, quot_in;
   logic                                  pend_valid_ff, pend_valid_in;
   logic [tow_pkg::INDEX_BITS-1:0]        pend_start_ff, pend_start_in;
   logic [tow_pkg::INDEX_BITS-1:0]        pend_end_ff, pend_end_in;
   logic [tow_pkg::CONF_BITS-1:0]         pend_conf_ff, pend_conf_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   tow_pkg::tow_rsp_type                  rsp_ff, rsp_in;

   logic signed [LB:0]                    num;
   logic signed [LB:0]                    den;
   logic [LB+1:0]                         trial;
   logic [tow_pkg::INDEX_BITS-1:0]        gap;
   logic                                  merge;
   logic                                  out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && !q_stat.empty;

   // Confidence operands: peak above floor over the floor's depth.
   assign num = {pop_data.peak[LB-1], pop_data.peak}
              - {cfg.floor_level[LB-1], cfg.floor_level};
   assign den = -{cfg.floor_level[LB-1], cfg.floor_level};

   // One restoring divide step.
   assign trial = {rem_ff, 1'b0} - {1'b0, den_ff};

   // Merge test against the held detection.
   assign gap   = ev_ff.start_index - pend_end_ff;
   assign merge = pend_valid_ff && (gap < cfg.min_gap_frames);

   always_comb begin
      state_in      = state_ff;
      ev_in         = ev_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quot_in       = quot_ff;
      pend_valid_in = pend_valid_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      pend_conf_in  = pend_conf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      case (state_ff)
         // Take the next event word and settle the easy confidence cases.
         ST_IDLE: begin
            if (pop) begin
               ev_in = pop_data;
               if (!pop_data.has_window) begin
                  state_in = ST_FLUSH;
               end else if (!cfg.floor_level[LB-1] || (num <= 0)) begin
                  quot_in  = tow_pkg::CONF_ZERO;
                  state_in = ST_RESOLVE;
               end else if (num >= den) begin
                  quot_in  = tow_pkg::CONF_ONE;
                  state_in = ST_RESOLVE;
               end else begin
                  rem_in   = num;
                  den_in   = den;
                  quot_in  = tow_pkg::CONF_ZERO;
                  step_in  = STEP_BITS'(tow_pkg::CONF_BITS - 1);
                  state_in = ST_DIVIDE;
               end
            end
         end
         // One quotient bit per cycle.
         ST_DIVIDE: begin
            if (!trial[LB+1]) begin
               rem_in  = trial[LB:0];
               quot_in = {quot_ff[tow_pkg::CONF_BITS-2:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[LB-1:0], 1'b0};
               quot_in = {quot_ff[tow_pkg::CONF_BITS-2:0], 1'b0};
            end
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = ST_RESOLVE;
            end
         end
         // Merge into the held detection, or push it out and hold the new one.
         ST_RESOLVE: begin
            if (merge) begin
               pend_end_in = ev_ff.end_index;
               if (quot_ff > pend_conf_ff) begin
                  pend_conf_in = quot_ff;
               end
               state_in = ev_ff.flush ? ST_FLUSH : ST_IDLE;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.start_index = pend_start_ff;
                  rsp_in.end_index   = pend_end_ff;
                  rsp_in.confidence  = pend_conf_ff;
                  rsp_in.last_of_run = !ev_ff.flush;
               end
               pend_valid_in = 1'b1;
               pend_start_in = ev_ff.start_index;
               pend_end_in   = ev_ff.end_index;
               pend_conf_in  = quot_ff;
               state_in      = ev_ff.flush ? ST_FLUSH : ST_IDLE;
            end
         end
         // End of buffer: emit whatever is still held.
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.start_index = pend_start_ff;
               rsp_in.end_index   = pend_end_ff;
               rsp_in.confidence  = pend_conf_ff;
               rsp_in.last_of_run = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff         <= ev_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      quot_ff       <= quot_in;
      pend_start_ff <= pend_start_in;
      pend_end_ff   <= pend_end_in;
      pend_conf_ff  <= pend_conf_in;
      rsp_ff        <= rsp_in;
   end

endmodule

// ===== hdl/transient_onset_window_detector.sv =====
`timescale 1ns / 1ps
// ============================================================================
// transient_onset_window_detector: onset window detector over hop frames
// Top level: register port, frame classifier, event queue and the
// confidence and merge engine.
// ============================================================================
// The front end takes one level word per clock while the event queue has
// room; frames that neither close a window nor end the buffer push nothing.
// For each event word (a closed window, the end of the buffer, or both) the
// back end takes it in the idle state, runs the serial confidence divide
// (one quotient bit per cycle), merges it or hands the held detection to
// the output register once that is free, and at the end of a buffer flushes
// what is held. Confidence values that are 0 or saturated skip the divide.
// A word ending the buffer may yield two result words; the output register
// lets the engine go on while a result waits to be taken. Registers must be
// written only while the block is idle; the block does not enforce this.
module transient_onset_window_detector #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tow_pkg::tow_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tow_pkg::tow_rsp_type              rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tow_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [tow_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [tow_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);

   tow_pkg::tow_cfg_type          cfg;
   tow_pkg::tow_queue_status_type q_stat;
   tow_pkg::tow_event_type        push_data;
   tow_pkg::tow_event_type        pop_data;
   logic                          q_push;
   logic                          q_pop;

   tow_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tow_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (q_push),
      .push_data (push_data)
   );

   tow_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   tow_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_stat    (q_stat),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // An event word is never offered to a full queue.
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("event pushed into a full queue");

   // The back end never takes a word from an empty queue.
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("event popped from an empty queue");

   // The last frame of a buffer always leaves a flush word in the queue.
   a_final_queued: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && req_ready && req_data.final_item) |=> !q_stat.empty)
      else $error("last frame of a buffer left no event word");

endmodule
